// ===== src/sdh_pkg.sv =====
// Package: types and constants shared by the SD card host register file.
`timescale 1ns / 1ps
package sdh_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned SlowW = 24;
  localparam int unsigned FastW = 8;
  localparam int unsigned WdogW = 16;
  localparam int unsigned CmdW  = 7;
  localparam int unsigned CrcW  = 7;

  // bus operation codes
  localparam logic [1:0] OpNone  = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpWrite = 2'd2;

  // register word indexes
  localparam logic [IdxW-1:0] RegDivisor  = 10'h000;
  localparam logic [IdxW-1:0] RegControl  = 10'h001;
  localparam logic [IdxW-1:0] RegWatchdog = 10'h002;
  localparam logic [IdxW-1:0] RegStatus   = 10'h004;
  localparam logic [IdxW-1:0] RegCmdLog   = 10'h005;
  localparam logic [IdxW-1:0] RegArgument = 10'h006;
  localparam logic [IdxW-1:0] RegIfCond   = 10'h008;

  // capture codes with this bit set carry no event
  localparam int unsigned CmdNoEventBit = 6;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IdxW-1:0]  reg_index;
    logic [DataW-1:0] write_data;
    logic             slow_clock_select;
    logic [4:0]       card_lines;
    logic [3:0]       error_code;
    logic [2:0]       card_type;
    logic [CmdW-1:0]  request_cmd;
    logic [CmdW-1:0]  response_cmd;
    logic [DataW-1:0] response_arg;
    logic [CrcW-1:0]  crc_received;
    logic [CrcW-1:0]  crc_computed;
  } sdh_in_t;

  typedef struct packed {
    logic             read_valid;
    logic [DataW-1:0] read_data;
    logic             sck_level;
    logic             sck_rise;
    logic             sck_fall;
    logic [WdogW-1:0] watchdog_value;
    logic             error_clear_pulse;
    logic             spi_mode_out;
    logic             pcie_12v_out;
    logic             pcie_avail_out;
    logic [3:0]       voltage_out;
    logic [7:0]       check_pattern_out;
  } sdh_out_t;

  typedef struct packed {
    logic advance;
    logic enable;
    logic slow_sel;
    logic restart;
  } sdh_div_ctl_t;

  typedef struct packed {
    logic level;
    logic rise;
    logic fall;
  } sdh_div_stat_t;

endpackage

// ===== src/sdh_stream_if.sv =====
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
interface sdh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/sdh_clk_div.sv =====
// Card clock divider: counter, compare against the selected divisor, level toggle.
`timescale 1ns / 1ps
module sdh_clk_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sdh_pkg::sdh_div_ctl_t      ctl_i,
  input  logic [sdh_pkg::SlowW-1:0]  slow_div_i,
  input  logic [sdh_pkg::FastW-1:0]  fast_div_i,
  output sdh_pkg::sdh_div_stat_t     stat_o
);
  import sdh_pkg::*;

  logic [SlowW-1:0] count_q, count_d;
  logic             level_q, level_d;
  logic [SlowW-1:0] limit;
  logic             hit;

  always_comb begin
    limit = ctl_i.slow_sel ? slow_div_i : {{(SlowW-FastW){1'b0}}, fast_div_i};
    hit   = ctl_i.enable && (count_q >= limit);
    if (ctl_i.restart || hit) begin
      count_d = '0;
    end else if (ctl_i.enable) begin
      count_d = count_q + SlowW'(1);
    end else begin
      count_d = count_q;
    end
    level_d = level_q ^ hit;
  end

  assign stat_o.level = level_q;
  assign stat_o.rise  = hit & ~level_q;
  assign stat_o.fall  = hit & level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= 1'b0;
    end else if (ctl_i.advance) begin
      count_q <= count_d;
      level_q <= level_d;
    end
  end
endmodule

// ===== src/sd_card_host_register_file.sv =====
// Top level: SD card host register file with card clock divider.
//
//  channel | dir | payload   | transfer
//  in_i    | in  | sdh_in_t  | valid & ready, one transaction per system tick
//  out_o   | out | sdh_out_t | valid & ready, one transaction per input
//
// One transaction per cycle while out_o is not stalled: state and the result
// register update at the accepting edge; the result appears on out_o the next cycle.
// in_i.ready stays high while the result register is empty or being drained,
// so transactions flow back to back. Async active-low reset clears all state but res_q.
// The divider only advances on accepted transactions.
`timescale 1ns / 1ps
module sd_card_host_register_file (
  input  logic         clk_i,
  input  logic         rst_ni,
  sdh_stream_if.sink   in_i,
  sdh_stream_if.source out_o
);
  import sdh_pkg::*;

  sdh_in_t          in_p;
  logic             accept;
  logic             access, wr;
  logic [DataW-1:0] rdata;
  sdh_div_ctl_t     div_ctl;
  sdh_div_stat_t    div_stat;
  sdh_out_t         res_d, res_q;
  logic             out_valid_q;

  logic             clk_en_q, spi_sel_q, clr_pend_q;
  logic [SlowW-1:0] slow_div_q;
  logic [FastW-1:0] fast_div_q;
  logic [WdogW-1:0] wdog_q;
  logic [5:0]       last_req_q, last_rsp_q;
  logic [CrcW-1:0]  last_crc_rx_q, last_crc_calc_q;
  logic [DataW-1:0] last_arg_q;
  logic             pcie_12v_q, pcie_avail_q;
  logic [3:0]       voltage_q;
  logic [7:0]       pattern_q;

  assign in_p     = in_i.payload;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  assign access   = (in_p.operation == OpRead) || (in_p.operation == OpWrite);
  assign wr       = (in_p.operation == OpWrite);

  always_comb begin
    unique case (in_p.reg_index)
      RegDivisor:  rdata = {fast_div_q, slow_div_q};
      RegControl:  rdata = {23'd0, in_p.card_lines, spi_sel_q, 2'b00, clk_en_q};
      RegWatchdog: rdata = {16'd0, wdog_q};
      RegStatus:   rdata = {17'd0, in_p.card_type, 8'd0, in_p.error_code};
      RegCmdLog:   rdata = {1'b0, last_crc_calc_q, 1'b0, last_crc_rx_q,
                            2'b00, last_rsp_q, 2'b00, last_req_q};
      RegArgument: rdata = last_arg_q;
      RegIfCond:   rdata = {18'd0, pcie_12v_q, pcie_avail_q, voltage_q, pattern_q};
      default:     rdata = '0;
    endcase
  end

  assign div_ctl.advance  = accept;
  assign div_ctl.enable   = clk_en_q;
  assign div_ctl.slow_sel = in_p.slow_clock_select;
  assign div_ctl.restart  = wr && (in_p.reg_index == RegDivisor);

  sdh_clk_div u_clk_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .slow_div_i (slow_div_q),
    .fast_div_i (fast_div_q),
    .stat_o     (div_stat)
  );

  always_comb begin
    res_d.read_valid        = access;
    res_d.read_data         = access ? rdata : '0;
    res_d.sck_level         = div_stat.level;
    res_d.sck_rise          = div_stat.rise;
    res_d.sck_fall          = div_stat.fall;
    res_d.watchdog_value    = wdog_q;
    res_d.error_clear_pulse = clr_pend_q;
    res_d.spi_mode_out      = spi_sel_q;
    res_d.pcie_12v_out      = pcie_12v_q;
    res_d.pcie_avail_out    = pcie_avail_q;
    res_d.voltage_out       = voltage_q;
    res_d.check_pattern_out = pattern_q;
  end

  // register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_en_q        <= 1'b0;
      spi_sel_q       <= 1'b0;
      clr_pend_q      <= 1'b0;
      slow_div_q      <= '0;
      fast_div_q      <= '0;
      wdog_q          <= '0;
      last_req_q      <= '0;
      last_rsp_q      <= '0;
      last_crc_rx_q   <= '0;
      last_crc_calc_q <= '0;
      last_arg_q      <= '0;
      pcie_12v_q      <= 1'b0;
      pcie_avail_q    <= 1'b0;
      voltage_q       <= '0;
      pattern_q       <= '0;
    end else if (accept) begin
      clr_pend_q <= 1'b0;
      if (!in_p.request_cmd[CmdNoEventBit]) begin
        last_req_q <= in_p.request_cmd[5:0];
      end
      if (!in_p.response_cmd[CmdNoEventBit]) begin
        last_rsp_q      <= in_p.response_cmd[5:0];
        last_crc_rx_q   <= in_p.crc_received;
        last_crc_calc_q <= in_p.crc_computed;
        last_arg_q      <= in_p.response_arg;
      end
      if (wr) begin
        unique case (in_p.reg_index)
          RegDivisor: begin
            fast_div_q <= in_p.write_data[31:24];
            slow_div_q <= in_p.write_data[23:0];
          end
          RegControl: begin
            clk_en_q   <= in_p.write_data[0];
            clr_pend_q <= in_p.write_data[1];
            spi_sel_q  <= in_p.write_data[3];
          end
          RegWatchdog: begin
            wdog_q <= in_p.write_data[15:0];
          end
          RegIfCond: begin
            pattern_q    <= in_p.write_data[7:0];
            voltage_q    <= in_p.write_data[11:8];
            pcie_avail_q <= in_p.write_data[12];
            pcie_12v_q   <= in_p.write_data[13];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = res_q;
endmodule

// ===== tb/sv/sd_card_host_register_file_tb.sv =====
// Testbench: predicts and checks every tick of the SD card host register file.
`timescale 1ns / 1ps
module sd_card_host_register_file_tb;
  import sdh_pkg::*;

  localparam logic [1:0]      OpUnused   = 2'd3;
  localparam logic [CmdW-1:0] CmdIdle    = 7'd64;
  localparam logic [IdxW-1:0] RegUnused  = 10'h003;
  localparam logic [IdxW-1:0] RegTop     = 10'h3FF;
  localparam int              CycleLimit = 200000;
  localparam int              IdlePct    = 36;

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   errors;
  int   cycles;

  sdh_stream_if #(.payload_t(sdh_in_t))  in_ch ();
  sdh_stream_if #(.payload_t(sdh_out_t)) out_ch ();

  sd_card_host_register_file dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predicted register file state
  logic             clk_en_q, spi_q, clr_pend_q, sck_q;
  logic [SlowW-1:0] slow_div_q, div_cnt_q;
  logic [FastW-1:0] fast_div_q;
  logic [WdogW-1:0] wdog_q;
  logic [5:0]       req_log_q, rsp_log_q;
  logic [CrcW-1:0]  crc_rx_q, crc_calc_q;
  logic [DataW-1:0] arg_q;
  logic             p12v_q, pavail_q;
  logic [3:0]       volt_q;
  logic [7:0]       pat_q;

  sdh_out_t tick_result_q[$];

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void clear_regfile_state();
    clk_en_q = 1'b0; spi_q = 1'b0; clr_pend_q = 1'b0; sck_q = 1'b0;
    slow_div_q = '0; div_cnt_q = '0; fast_div_q = '0; wdog_q = '0;
    req_log_q = '0; rsp_log_q = '0; crc_rx_q = '0; crc_calc_q = '0;
    arg_q = '0; p12v_q = 1'b0; pavail_q = 1'b0; volt_q = '0; pat_q = '0;
  endfunction

  function automatic sdh_out_t regfile_tick(input sdh_in_t it);
    sdh_out_t         r;
    logic [DataW-1:0] rd;
    logic [SlowW-1:0] lim;
    logic             access;
    r = '0;
    access = (it.operation == OpRead) || (it.operation == OpWrite);
    r.sck_level         = sck_q;
    r.watchdog_value    = wdog_q;
    r.error_clear_pulse = clr_pend_q;
    r.spi_mode_out      = spi_q;
    r.pcie_12v_out      = p12v_q;
    r.pcie_avail_out    = pavail_q;
    r.voltage_out       = volt_q;
    r.check_pattern_out = pat_q;
    case (it.reg_index)
      RegDivisor:  rd = {fast_div_q, slow_div_q};
      RegControl:  rd = {23'd0, it.card_lines, spi_q, 2'b00, clk_en_q};
      RegWatchdog: rd = {16'd0, wdog_q};
      RegStatus:   rd = {17'd0, it.card_type, 8'd0, it.error_code};
      RegCmdLog:   rd = {1'b0, crc_calc_q, 1'b0, crc_rx_q, 2'b00, rsp_log_q,
                         2'b00, req_log_q};
      RegArgument: rd = arg_q;
      RegIfCond:   rd = {18'd0, p12v_q, pavail_q, volt_q, pat_q};
      default:     rd = '0;
    endcase

    clr_pend_q = 1'b0;
    if (!it.request_cmd[CmdNoEventBit]) req_log_q = it.request_cmd[5:0];
    if (!it.response_cmd[CmdNoEventBit]) begin
      rsp_log_q  = it.response_cmd[5:0];
      crc_rx_q   = it.crc_received;
      crc_calc_q = it.crc_computed;
      arg_q      = it.response_arg;
    end

    if (clk_en_q) begin
      lim = it.slow_clock_select ? slow_div_q : {16'd0, fast_div_q};
      if (div_cnt_q >= lim) begin
        div_cnt_q  = '0;
        r.sck_rise = !sck_q;
        r.sck_fall = sck_q;
        sck_q      = !sck_q;
      end else begin
        div_cnt_q = div_cnt_q + SlowW'(1);
      end
    end

    if (it.operation == OpWrite) begin
      case (it.reg_index)
        RegDivisor: begin
          fast_div_q = it.write_data[31:24];
          slow_div_q = it.write_data[23:0];
          div_cnt_q  = '0;
        end
        RegControl: begin
          clk_en_q   = it.write_data[0];
          clr_pend_q = it.write_data[1];
          spi_q      = it.write_data[3];
        end
        RegWatchdog: wdog_q = it.write_data[15:0];
        RegIfCond: begin
          pat_q    = it.write_data[7:0];
          volt_q   = it.write_data[11:8];
          pavail_q = it.write_data[12];
          p12v_q   = it.write_data[13];
        end
        default: ;
      endcase
    end

    r.read_valid = access;
    r.read_data  = access ? rd : '0;
    return r;
  endfunction

  function automatic void chk_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(input sdh_out_t got);
    sdh_out_t want;
    if (tick_result_q.size() == 0) begin
      $error("out_o transaction with no result expected");
      errors++;
      return;
    end
    want = tick_result_q.pop_front();
    chk_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
    chk_field("read_data", want.read_data, got.read_data);
    chk_field("sck_level", 32'(want.sck_level), 32'(got.sck_level));
    chk_field("sck_rise", 32'(want.sck_rise), 32'(got.sck_rise));
    chk_field("sck_fall", 32'(want.sck_fall), 32'(got.sck_fall));
    chk_field("watchdog_value", 32'(want.watchdog_value), 32'(got.watchdog_value));
    chk_field("error_clear_pulse", 32'(want.error_clear_pulse),
              32'(got.error_clear_pulse));
    chk_field("spi_mode_out", 32'(want.spi_mode_out), 32'(got.spi_mode_out));
    chk_field("pcie_12v_out", 32'(want.pcie_12v_out), 32'(got.pcie_12v_out));
    chk_field("pcie_avail_out", 32'(want.pcie_avail_out), 32'(got.pcie_avail_out));
    chk_field("voltage_out", 32'(want.voltage_out), 32'(got.voltage_out));
    chk_field("check_pattern_out", 32'(want.check_pattern_out),
              32'(got.check_pattern_out));
  endfunction

  // check first: a result never belongs to the transaction accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.payload);
      if (in_ch.valid && in_ch.ready) tick_result_q.push_back(regfile_tick(in_ch.payload));
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic send_tick(input sdh_in_t it);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic sdh_in_t bus_tick(input logic [1:0] op, input logic [IdxW-1:0] idx,
                                       input logic [DataW-1:0] wd);
    sdh_in_t it;
    it = '0;
    it.operation    = op;
    it.reg_index    = idx;
    it.write_data   = wd;
    it.request_cmd  = CmdIdle;
    it.response_cmd = CmdIdle;
    return it;
  endfunction

  task automatic test_reset_values();
    sdh_in_t it;
    send_tick(bus_tick(OpRead, RegDivisor, '0));
    it = bus_tick(OpRead, RegControl, '0);
    it.card_lines = '1;
    send_tick(it);
    send_tick(bus_tick(OpRead, RegWatchdog, '0));
    it = bus_tick(OpRead, RegStatus, '0);
    it.error_code = '1;
    it.card_type  = '1;
    send_tick(it);
    send_tick(bus_tick(OpRead, RegCmdLog, '0));
    send_tick(bus_tick(OpRead, RegArgument, '0));
    send_tick(bus_tick(OpRead, RegIfCond, '0));
  endtask

  task automatic test_register_access();
    send_tick(bus_tick(OpWrite, RegWatchdog, '1));
    send_tick(bus_tick(OpWrite, RegIfCond, '1));
    send_tick(bus_tick(OpWrite, RegControl, 32'h0000_000A));
    send_tick(bus_tick(OpWrite, RegStatus, '1));
    send_tick(bus_tick(OpWrite, RegTop, '1));
    send_tick(bus_tick(OpUnused, RegWatchdog, 32'h0000_1234));
    send_tick(bus_tick(OpRead, RegUnused, '0));
  endtask

  task automatic test_capture();
    sdh_in_t it;
    it = bus_tick(OpNone, RegCmdLog, '0);
    it.request_cmd  = 7'd63;
    it.response_cmd = '0;
    it.response_arg = '1;
    it.crc_received = '1;
    send_tick(it);
    it = bus_tick(OpRead, RegCmdLog, '0);
    it.request_cmd  = '0;
    it.response_cmd = 7'd63;
    it.crc_computed = '1;
    send_tick(it);
    it = bus_tick(OpRead, RegArgument, '0);
    it.request_cmd  = '1;
    it.response_cmd = 7'd100;
    it.response_arg = 32'h5A5A_A5A5;
    send_tick(it);
  endtask

  task automatic test_divider();
    sdh_in_t it;
    send_tick(bus_tick(OpWrite, RegControl, 32'h0000_0001));
    for (int i = 0; i < 3; i++) begin
      it = bus_tick(OpNone, RegDivisor, '0);
      it.slow_clock_select = i[0];
      send_tick(it);
    end
    send_tick(bus_tick(OpWrite, RegDivisor, 32'hFF00_0002));
    for (int i = 0; i < 4; i++) begin
      it = bus_tick(OpNone, RegDivisor, '0);
      it.slow_clock_select = 1'b1;
      send_tick(it);
    end
    send_tick(bus_tick(OpWrite, RegDivisor, '1));
    send_tick(bus_tick(OpRead, RegDivisor, '0));
  endtask

  function automatic logic [CmdW-1:0] random_cmd();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return CmdIdle;
    if (pick < 90) return CmdW'($urandom_range(63));
    return CmdW'($urandom_range(127, 65));
  endfunction

  function automatic sdh_in_t random_tick();
    sdh_in_t      it;
    logic [127:0] raw;
    int unsigned  pick;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(sdh_in_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 35) it.operation = OpNone;
    else if (pick < 65) it.operation = OpRead;
    else if (pick < 95) it.operation = OpWrite;
    else it.operation = OpUnused;
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(6))
        0: it.reg_index = RegDivisor;
        1: it.reg_index = RegControl;
        2: it.reg_index = RegWatchdog;
        3: it.reg_index = RegStatus;
        4: it.reg_index = RegCmdLog;
        5: it.reg_index = RegArgument;
        default: it.reg_index = RegIfCond;
      endcase
    end
    if (it.reg_index == RegDivisor && $urandom_range(9) != 0) begin
      it.write_data[31:24] = FastW'($urandom_range(6));
      it.write_data[23:0]  = SlowW'($urandom_range(12));
    end
    if (it.reg_index == RegControl && $urandom_range(99) < 85) it.write_data[0] = 1'b1;
    it.request_cmd  = random_cmd();
    it.response_cmd = random_cmd();
    return it;
  endfunction

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3) && (i < n / 3 + 350);
      send_tick(random_tick());
    end
    calm = 1'b0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    calm   = 1'b0;
    clear_regfile_state();
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_register_access();
    test_capture();
    test_divider();
    test_random_traffic(1350);

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tick_result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sdh_pkg.sv
src/sdh_stream_if.sv
src/sdh_clk_div.sv
src/sd_card_host_register_file.sv
tb/sv/sd_card_host_register_file_tb.sv
